### rtl/core/tcw_pkg.sv
package tcw_pkg;

    // Screen geometry and tab spacing.
    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int TAB_WIDTH = 8;
    localparam int CELLS     = ROWS * COLUMNS;
    localparam int ADDR_W    = $clog2(CELLS);

    // Field widths.
    localparam int COL_W     = 7;
    localparam int ROW_W     = 5;
    localparam int CHAR_W    = 8;
    localparam int DATA_W    = 16;
    localparam int CMD_W     = 2;
    localparam int COLOR_W   = 4;
    localparam int CFG_IDX_W = 2;

    // Command queue between the front and the back.
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG = 2'd1;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'hf;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

    // Character codes with special handling.
    localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_ESC   = 8'd27;
    localparam logic [CHAR_W-1:0] CH_DEL   = 8'd127;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

    // Operation classes produced by the front.
    typedef enum logic [3:0] {
        OP_PUT,
        OP_LF,
        OP_CR,
        OP_TAB,
        OP_BS,
        OP_DEL,
        OP_NOP,
        OP_READ,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } t_item;

    // Request group from the back to the screen memory.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_FILL
    } t_state;

    // Next tab stop for every cursor column, clamped to the last column.
    typedef logic [(1 << COL_W)-1:0][COL_W-1:0] t_tab_tbl;

    function automatic t_tab_tbl build_tab_tbl();
        t_tab_tbl tbl;
        int       t;
        for (int i = 0; i < (1 << COL_W); i++) begin
            t = i + TAB_WIDTH - (i % TAB_WIDTH);
            if (t >= COLUMNS) begin
                t = COLUMNS - 1;
            end
            tbl[i] = COL_W'(t);
        end
        return tbl;
    endfunction

    localparam t_tab_tbl TAB_STOP = build_tab_tbl();

endpackage

### rtl/core/tcw_ram.sv
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/tcw_front.sv
module tcw_front (
    input  logic                         start,
    output logic                         busy,
    input  logic [tcw_pkg::CMD_W-1:0]    i_command,
    input  logic [tcw_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tcw_pkg::ROW_W-1:0]    i_read_row,
    input  logic [tcw_pkg::COL_W-1:0]    i_read_column,
    input  logic                         i_full,
    input  logic                         i_init,
    output logic                         o_push,
    output tcw_pkg::t_item               o_item
);

    tcw_pkg::t_op op;

    // Commands are refused while the queue is full or the screen is being cleared after reset.
    assign busy   = i_full | i_init;
    assign o_push = start & ~busy;

    // Classify the command, and for put character the byte, into one operation.
    always_comb begin
        unique case (i_command)
            tcw_pkg::CMD_PUT: begin
                unique case (i_char_code)
                    tcw_pkg::CH_LF:  op = tcw_pkg::OP_LF;
                    tcw_pkg::CH_CR:  op = tcw_pkg::OP_CR;
                    tcw_pkg::CH_TAB: op = tcw_pkg::OP_TAB;
                    tcw_pkg::CH_BS:  op = tcw_pkg::OP_BS;
                    tcw_pkg::CH_DEL: op = tcw_pkg::OP_DEL;
                    tcw_pkg::CH_ESC: op = tcw_pkg::OP_NOP;
                    default:         op = tcw_pkg::OP_PUT;
                endcase
            end
            tcw_pkg::CMD_READ:  op = tcw_pkg::OP_READ;
            tcw_pkg::CMD_CLEAR: op = tcw_pkg::OP_CLEAR;
            default:            op = tcw_pkg::OP_NOP;
        endcase
    end

    assign o_item.op        = op;
    assign o_item.char_code = i_char_code;
    assign o_item.read_row  = i_read_row;
    assign o_item.read_col  = i_read_column;

endmodule

### rtl/core/tcw_queue.sv
module tcw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tcw_pkg::t_item i_item,
    input  logic           i_pop,
    output tcw_pkg::t_item o_item,
    output logic           o_full,
    output logic           o_empty
);

    tcw_pkg::t_item                r_mem [tcw_pkg::QDEPTH];
    logic [tcw_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [tcw_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [tcw_pkg::QCNT_W-1:0]    r_count;
    logic [tcw_pkg::QPTR_W-1:0]    n_wr_ptr;
    logic [tcw_pkg::QPTR_W-1:0]    n_rd_ptr;
    logic [tcw_pkg::QCNT_W-1:0]    n_count;

    localparam logic [tcw_pkg::QPTR_W-1:0] PTR_LAST = tcw_pkg::QPTR_W'(tcw_pkg::QDEPTH - 1);
    localparam logic [tcw_pkg::QCNT_W-1:0] CNT_FULL = tcw_pkg::QCNT_W'(tcw_pkg::QDEPTH);

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Pointer and occupancy update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // The front must never offer a transfer into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && (r_count == CNT_FULL)))
        else $error("queue written while full");

    // The back must never take from an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && (r_count == '0)))
        else $error("queue read while empty");

    // Occupancy never exceeds the depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue occupancy out of range");

endmodule

### rtl/core/tcw_back.sv
module tcw_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [tcw_pkg::COLOR_W-1:0]   i_fg,
    input  logic [tcw_pkg::COLOR_W-1:0]   i_bg,
    input  tcw_pkg::t_item                i_item,
    input  logic                          i_empty,
    output logic                          o_pop,
    output logic                          o_init,
    output tcw_pkg::t_ram_req             o_ram,
    input  logic [tcw_pkg::DATA_W-1:0]    i_rdata,
    output logic                          o_done,
    output logic [tcw_pkg::COL_W-1:0]     o_cursor_column,
    output logic [tcw_pkg::ROW_W-1:0]     o_cursor_row,
    output logic [tcw_pkg::DATA_W-1:0]    o_cell_data,
    output logic                          o_scrolled
);

    localparam int AW = tcw_pkg::ADDR_W;
    localparam int CW = tcw_pkg::COL_W;
    localparam int RW = tcw_pkg::ROW_W;
    localparam int DW = tcw_pkg::DATA_W;

    localparam logic [CW-1:0] COL_LAST  = CW'(tcw_pkg::COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST  = RW'(tcw_pkg::ROWS - 1);
    localparam logic [AW-1:0] CELL_LAST = AW'(tcw_pkg::CELLS - 1);
    localparam logic [AW-1:0] ROW_SPAN  = AW'(tcw_pkg::COLUMNS - 1);

    // Logical row plus the top-of-screen offset gives the physical row in memory.
    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] row,
                                                input logic [CW-1:0] col,
                                                input logic [RW-1:0] top);
        logic [RW:0]   sum;
        logic [RW-1:0] phys;
        sum = {1'b0, row} + {1'b0, top};
        if (sum >= (RW + 1)'(tcw_pkg::ROWS)) begin
            sum = sum - (RW + 1)'(tcw_pkg::ROWS);
        end
        phys = sum[RW-1:0];
        return AW'(AW'(phys) * AW'(tcw_pkg::COLUMNS)) + AW'(col);
    endfunction

    tcw_pkg::t_state r_state;
    tcw_pkg::t_state n_state;
    logic [CW-1:0]   r_cx;
    logic [CW-1:0]   n_cx;
    logic [RW-1:0]   r_cy;
    logic [RW-1:0]   n_cy;
    logic [RW-1:0]   r_top;
    logic [RW-1:0]   n_top;
    logic [AW-1:0]   r_fill_addr;
    logic [AW-1:0]   n_fill_addr;
    logic [AW-1:0]   r_fill_last;
    logic [AW-1:0]   n_fill_last;
    logic [DW-1:0]   r_fill_word;
    logic [DW-1:0]   n_fill_word;
    logic            r_pend_scr;
    logic            n_pend_scr;
    logic            r_out_valid;
    logic            n_out_valid;
    logic [CW-1:0]   r_out_col;
    logic [CW-1:0]   n_out_col;
    logic [RW-1:0]   r_out_row;
    logic [RW-1:0]   n_out_row;
    logic [DW-1:0]   r_out_data;
    logic [DW-1:0]   n_out_data;
    logic            r_out_scr;
    logic            n_out_scr;

    logic            pop;
    logic            fill_done;
    logic            go_fill;
    logic            go_read;
    logic            adv_row;
    logic            scroll;
    logic            read_ok;
    logic [RW-1:0]   wr_row;
    logic [CW-1:0]   wr_col;
    logic [DW-1:0]   fill_word;
    logic [DW-1:0]   char_word;
    logic [DW-1:0]   space_word;
    logic [AW-1:0]   top_row_base;

    assign pop          = (r_state == tcw_pkg::ST_IDLE) && !i_empty;
    assign fill_done    = (r_fill_addr == r_fill_last);
    assign fill_word    = {i_bg, i_bg, i_bg, i_bg};
    assign char_word    = {i_bg, i_fg, i_item.char_code};
    assign space_word   = {i_bg, i_fg, tcw_pkg::CH_SPACE};
    assign top_row_base = cell_addr('0, '0, r_top);
    assign read_ok      = (i_item.read_row < RW'(tcw_pkg::ROWS))
                        && (i_item.read_col < CW'(tcw_pkg::COLUMNS));
    assign adv_row      = ((i_item.op == tcw_pkg::OP_PUT) && (r_cx == COL_LAST))
                        || (i_item.op == tcw_pkg::OP_LF);
    assign scroll       = adv_row && (r_cy == ROW_LAST);
    assign go_fill      = pop && (scroll || (i_item.op == tcw_pkg::OP_CLEAR));
    assign go_read      = pop && (i_item.op == tcw_pkg::OP_READ) && read_ok;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcw_pkg::ST_INIT: begin
                if (fill_done) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE: begin
                if (go_fill) begin
                    n_state = tcw_pkg::ST_FILL;
                end else if (go_read) begin
                    n_state = tcw_pkg::ST_READ;
                end
            end
            tcw_pkg::ST_READ: n_state = tcw_pkg::ST_IDLE;
            tcw_pkg::ST_FILL: begin
                if (fill_done) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            default: n_state = tcw_pkg::ST_IDLE;
        endcase
    end

    // Cursor, memory request and result for the state and the operation at hand.
    always_comb begin
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_top       = r_top;
        n_fill_addr = r_fill_addr;
        n_fill_last = r_fill_last;
        n_fill_word = r_fill_word;
        n_pend_scr  = r_pend_scr;
        n_out_valid = 1'b0;
        n_out_col   = r_cx;
        n_out_row   = r_cy;
        n_out_data  = '0;
        n_out_scr   = 1'b0;
        wr_row      = r_cy;
        wr_col      = r_cx;
        o_ram.we    = 1'b0;
        o_ram.wdata = char_word;
        o_ram.raddr = cell_addr(i_item.read_row, i_item.read_col, r_top);

        unique case (r_state)
            tcw_pkg::ST_INIT, tcw_pkg::ST_FILL: begin
                // Sweep the fill word over the address range, one cell a cycle.
                o_ram.we    = 1'b1;
                o_ram.wdata = r_fill_word;
                n_fill_addr = r_fill_addr + 1'b1;
                if (fill_done && (r_state == tcw_pkg::ST_FILL)) begin
                    n_out_valid = 1'b1;
                    n_out_scr   = r_pend_scr;
                end
            end
            tcw_pkg::ST_READ: begin
                n_out_valid = 1'b1;
                n_out_data  = i_rdata;
            end
            tcw_pkg::ST_IDLE: begin
                if (pop) begin
                    case (i_item.op)
                        tcw_pkg::OP_PUT: begin
                            o_ram.we = 1'b1;
                            n_cx     = (r_cx == COL_LAST) ? '0 : r_cx + 1'b1;
                        end
                        tcw_pkg::OP_LF:  n_cx = '0;
                        tcw_pkg::OP_CR:  n_cx = '0;
                        tcw_pkg::OP_TAB: n_cx = tcw_pkg::TAB_STOP[r_cx];
                        tcw_pkg::OP_BS: begin
                            // Step back, wrapping to the end of the previous line; nothing at home.
                            o_ram.wdata = space_word;
                            if (r_cx != '0) begin
                                o_ram.we = 1'b1;
                                n_cx     = r_cx - 1'b1;
                                wr_col   = r_cx - 1'b1;
                            end else if (r_cy != '0) begin
                                o_ram.we = 1'b1;
                                n_cx     = COL_LAST;
                                n_cy     = r_cy - 1'b1;
                                wr_col   = COL_LAST;
                                wr_row   = r_cy - 1'b1;
                            end
                        end
                        tcw_pkg::OP_DEL: begin
                            o_ram.we    = 1'b1;
                            o_ram.wdata = space_word;
                        end
                        default: ;
                    endcase

                    // Line advance: move down, or scroll by rotating the top row.
                    if (adv_row) begin
                        if (scroll) begin
                            n_top       = (r_top == ROW_LAST) ? '0 : r_top + 1'b1;
                            n_fill_addr = top_row_base;
                            n_fill_last = top_row_base + ROW_SPAN;
                            n_fill_word = fill_word;
                            n_pend_scr  = 1'b1;
                        end else begin
                            n_cy = r_cy + 1'b1;
                        end
                    end

                    if (i_item.op == tcw_pkg::OP_CLEAR) begin
                        n_fill_addr = '0;
                        n_fill_last = CELL_LAST;
                        n_fill_word = fill_word;
                        n_pend_scr  = 1'b0;
                    end

                    // Results that need no further cycles leave at once.
                    if (!go_fill && !go_read) begin
                        n_out_valid = 1'b1;
                        n_out_col   = n_cx;
                        n_out_row   = n_cy;
                    end
                end
            end
            default: ;
        endcase

        o_ram.waddr = (r_state == tcw_pkg::ST_IDLE) ? cell_addr(wr_row, wr_col, r_top)
                                                    : r_fill_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::ST_INIT;
            r_cx        <= '0;
            r_cy        <= '0;
            r_top       <= '0;
            r_fill_addr <= '0;
            r_fill_last <= CELL_LAST;
            r_fill_word <= '0;
            r_pend_scr  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_top       <= n_top;
            r_fill_addr <= n_fill_addr;
            r_fill_last <= n_fill_last;
            r_fill_word <= n_fill_word;
            r_pend_scr  <= n_pend_scr;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge i_clk) begin
        r_out_col  <= n_out_col;
        r_out_row  <= n_out_row;
        r_out_data <= n_out_data;
        r_out_scr  <= n_out_scr;
    end

    assign o_pop           = pop;
    assign o_init          = (r_state == tcw_pkg::ST_INIT);
    assign o_done          = r_out_valid;
    assign o_cursor_column = r_out_col;
    assign o_cursor_row    = r_out_row;
    assign o_cell_data     = r_out_data;
    assign o_scrolled      = r_out_scr;

    // The top-row offset and the cursor stay on the screen.
    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top < RW'(tcw_pkg::ROWS))
        else $error("top row offset out of range");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cx < CW'(tcw_pkg::COLUMNS)) && (r_cy < RW'(tcw_pkg::ROWS)))
        else $error("cursor off screen");

    // A sweep never runs past its last address.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == tcw_pkg::ST_FILL) || (r_state == tcw_pkg::ST_INIT))
        |-> (r_fill_addr <= r_fill_last))
        else $error("fill sweep overran");

    // A memory read is always followed by its result.
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcw_pkg::ST_READ) |=> r_out_valid)
        else $error("read produced no result");

endmodule

### rtl/core/text_console_character_writer_top.sv
// Channel   Transfer condition               Carries
// -------   ------------------------------   ------------------------------------------
// command   start high, busy low             command, char_code, read_row, read_column
// result    o_done high for one cycle        cursor_column, cursor_row, cell_data, scrolled
// config    i_cfg_valid and o_cfg_ready      register index, colour nibble
//
// A plain character, control code, unknown command or off-screen read has its result
// registered when the back takes it from the queue; an on-screen read first goes through
// the registered read port. A scroll fills one row of the screen memory and a clear fills
// the whole screen; the memory has a single write port, so a fill writes one cell at a time.
// After reset a pass clearing all ROWS * COLUMNS cells (2000) holds busy high. The two-entry
// queue takes commands while the back works and raises busy when full; results cannot stall.
module text_console_character_writer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [tcw_pkg::CMD_W-1:0]        i_command,
    input  logic [tcw_pkg::CHAR_W-1:0]       i_char_code,
    input  logic [tcw_pkg::ROW_W-1:0]        i_read_row,
    input  logic [tcw_pkg::COL_W-1:0]        i_read_column,
    output logic                             o_done,
    output logic [tcw_pkg::COL_W-1:0]        o_cursor_column,
    output logic [tcw_pkg::ROW_W-1:0]        o_cursor_row,
    output logic [tcw_pkg::DATA_W-1:0]       o_cell_data,
    output logic                             o_scrolled,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tcw_pkg::COLOR_W-1:0]      i_cfg_data
);

    logic [tcw_pkg::COLOR_W-1:0] r_fg;
    logic [tcw_pkg::COLOR_W-1:0] r_bg;
    logic                        cfg_write;
    logic                        push;
    logic                        pop;
    logic                        q_full;
    logic                        q_empty;
    logic                        init;
    tcw_pkg::t_item              front_item;
    tcw_pkg::t_item              queue_item;
    tcw_pkg::t_ram_req           ram_req;
    logic [tcw_pkg::DATA_W-1:0]  ram_rdata;

    // Colour registers; a transfer to an index beyond the list is dropped.
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= tcw_pkg::FG_RESET;
            r_bg <= tcw_pkg::BG_RESET;
        end else if (cfg_write) begin
            if (i_cfg_index == tcw_pkg::CFG_FG) begin
                r_fg <= i_cfg_data;
            end
            if (i_cfg_index == tcw_pkg::CFG_BG) begin
                r_bg <= i_cfg_data;
            end
        end
    end

    // Front: accept and classify commands.
    tcw_front u_front (
        .start         (start),
        .busy          (busy),
        .i_command     (i_command),
        .i_char_code   (i_char_code),
        .i_read_row    (i_read_row),
        .i_read_column (i_read_column),
        .i_full        (q_full),
        .i_init        (init),
        .o_push        (push),
        .o_item        (front_item)
    );

    // Queue between front and back.
    tcw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back: cursor, screen updates, sweeps and results.
    tcw_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fg            (r_fg),
        .i_bg            (r_bg),
        .i_item          (queue_item),
        .i_empty         (q_empty),
        .o_pop           (pop),
        .o_init          (init),
        .o_ram           (ram_req),
        .i_rdata         (ram_rdata),
        .o_done          (o_done),
        .o_cursor_column (o_cursor_column),
        .o_cursor_row    (o_cursor_row),
        .o_cell_data     (o_cell_data),
        .o_scrolled      (o_scrolled)
    );

    // Screen memory, rows stored in rotated order.
    tcw_ram #(
        .WIDTH (tcw_pkg::DATA_W),
        .DEPTH (tcw_pkg::CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

endmodule
